// ===== sv/bmpargb_pkg.sv =====
package bmpargb_pkg;

	// Widths fixed by the register map and the result fields.
	localparam int CFG_W      = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int DIM_CFG_W  = 13;
	localparam int ORIGIN_W   = 12;
	localparam int COORD_W    = 13;
	localparam int COLOR_W    = 32;
	localparam int BYTE_W     = 8;

	// Default largest image side in pixels.
	localparam int DEFAULT_MAX_DIM = 4096;

	// Largest screen coordinate; positions beyond it saturate.
	localparam logic [COORD_W-1:0] COORD_MAX = 13'd8191;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE_32BIT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_PADDING  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd5;

	// Which byte of the pixel comes next.
	typedef enum logic [3:0] {
		PH_BLUE  = 4'b0001,
		PH_GREEN = 4'b0010,
		PH_RED   = 4'b0100,
		PH_ALPHA = 4'b1000
	} phase_t;

endpackage

// ===== sv/bmp_pixel_stream_to_argb_top.sv =====
// An accepted byte is registered; the pixel it completes is registered in the result register.
// Throughput: one byte per cycle while results are taken. A waiting result holds the byte that
// completes the next pixel in the input register, and in_ready stays low until the result goes.
// Reset: arst_n clears the byte phase, the row, column and padding counters, the valid flags and
// the configuration registers (width and height to 1, the rest to 0); colour holds are not reset.
module bmp_pixel_stream_to_argb_top #(
	parameter int MAX_DIM = bmpargb_pkg::DEFAULT_MAX_DIM
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [bmpargb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bmpargb_pkg::CFG_W-1:0]         cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [bmpargb_pkg::BYTE_W-1:0]        data_byte,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [bmpargb_pkg::COORD_W-1:0]       pixel_x,
	output logic [bmpargb_pkg::COORD_W-1:0]       pixel_y,
	output logic [bmpargb_pkg::COLOR_W-1:0]       pixel_color,
	output logic                                  image_done
);
	import bmpargb_pkg::*;

	// Counters hold 0..MAX_DIM-1; effective sizes hold 1..MAX_DIM.
	localparam int CNT_W = $clog2(MAX_DIM);
	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int CMP_W = (DIM_W > DIM_CFG_W) ? DIM_W : DIM_CFG_W;
	localparam int SUM_W = ((DIM_W > ORIGIN_W) ? DIM_W : ORIGIN_W) + 1;

	// Configuration registers.
	logic [DIM_CFG_W-1:0] width_q;
	logic [DIM_CFG_W-1:0] height_q;
	logic                 mode_q;
	logic [1:0]           padding_q;
	logic [ORIGIN_W-1:0]  origin_x_q;
	logic [ORIGIN_W-1:0]  origin_y_q;

	// Input register.
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// Unpacker state.
	phase_t            phase_q;
	logic [BYTE_W-1:0] blue_q;
	logic [BYTE_W-1:0] green_q;
	logic [BYTE_W-1:0] red_q;
	logic [CNT_W-1:0]  column_q;
	logic [CNT_W-1:0]  row_q;
	logic [1:0]        pad_q;

	// Result register.
	logic               out_valid_q;
	logic [COORD_W-1:0] pixel_x_q;
	logic [COORD_W-1:0] pixel_y_q;
	logic [COLOR_W-1:0] pixel_color_q;
	logic               image_done_q;

	logic               padding_byte;
	logic               produce;
	logic               out_free;
	logic               fire_s1;
	logic [CMP_W-1:0]   width_ext;
	logic [CMP_W-1:0]   height_ext;
	logic [DIM_W-1:0]   width_eff;
	logic [DIM_W-1:0]   height_eff;
	logic [DIM_W-1:0]   column_next;
	logic [DIM_W-1:0]   row_next;
	logic [DIM_W-1:0]   row_ext;
	logic [DIM_W-1:0]   flip_offs;
	logic               row_end;
	logic               last_row;
	logic [SUM_W-1:0]   x_sum;
	logic [SUM_W-1:0]   y_sum;
	logic [COORD_W-1:0] x_sat;
	logic [COORD_W-1:0] y_sat;
	logic [BYTE_W-1:0]  red_now;
	logic [BYTE_W-1:0]  alpha_now;

	// Configuration writes; indexes outside the map are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= DIM_CFG_W'(1);
			height_q   <= DIM_CFG_W'(1);
			mode_q     <= 1'b0;
			padding_q  <= 2'd0;
			origin_x_q <= '0;
			origin_y_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q    <= cfg_data[DIM_CFG_W-1:0];
				REG_IMAGE_HEIGHT: height_q   <= cfg_data[DIM_CFG_W-1:0];
				REG_MODE_32BIT:   mode_q     <= cfg_data[0];
				REG_ROW_PADDING:  padding_q  <= cfg_data[1:0];
				REG_ORIGIN_X:     origin_x_q <= cfg_data[ORIGIN_W-1:0];
				REG_ORIGIN_Y:     origin_y_q <= cfg_data[ORIGIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective image size: zero acts as one, oversize is clamped to MAX_DIM.
	always_comb begin
		width_ext  = CMP_W'(width_q);
		height_ext = CMP_W'(height_q);
		if (width_ext == '0) begin
			width_eff = DIM_W'(1);
		end else if (width_ext > CMP_W'(MAX_DIM)) begin
			width_eff = DIM_W'(MAX_DIM);
		end else begin
			width_eff = width_ext[DIM_W-1:0];
		end
		if (height_ext == '0) begin
			height_eff = DIM_W'(1);
		end else if (height_ext > CMP_W'(MAX_DIM)) begin
			height_eff = DIM_W'(MAX_DIM);
		end else begin
			height_eff = height_ext[DIM_W-1:0];
		end
	end

	// Row and image ends, the vertical flip and the saturated screen position.
	always_comb begin
		column_next = DIM_W'(column_q) + DIM_W'(1);
		row_ext     = DIM_W'(row_q);
		row_next    = row_ext + DIM_W'(1);
		row_end     = column_next >= width_eff;
		last_row    = row_next >= height_eff;
		flip_offs   = (row_ext < height_eff) ? (height_eff - row_next) : '0;
		x_sum       = SUM_W'(origin_x_q) + SUM_W'(column_q);
		y_sum       = SUM_W'(origin_y_q) + SUM_W'(flip_offs);
		x_sat       = (x_sum > SUM_W'(COORD_MAX)) ? COORD_MAX : x_sum[COORD_W-1:0];
		y_sat       = (y_sum > SUM_W'(COORD_MAX)) ? COORD_MAX : y_sum[COORD_W-1:0];
	end

	// A pixel completes on the red byte in 24-bit mode, or on any byte taken as alpha.
	always_comb begin
		padding_byte = pad_q != 2'd0;
		produce      = !padding_byte &&
			(((phase_q == PH_RED) && !mode_q) || (phase_q == PH_ALPHA));
		red_now      = (phase_q == PH_RED) ? byte_s1 : red_q;
		alpha_now    = (phase_q == PH_ALPHA) ? byte_s1 : '0;
	end

	// The held byte moves on unless it completes a pixel and the result slot is taken.
	assign out_free = !out_valid_q || out_ready;
	assign fire_s1  = valid_s1 && (!produce || out_free);
	assign in_ready = !valid_s1 || fire_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
		end
	end

	// Byte phase, padding skip and row and column counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_BLUE;
			column_q <= '0;
			row_q    <= '0;
			pad_q    <= 2'd0;
		end else if (fire_s1) begin
			if (padding_byte) begin
				pad_q <= pad_q - 2'd1;
			end else begin
				case (phase_q)
					PH_BLUE:  phase_q <= PH_GREEN;
					PH_GREEN: phase_q <= PH_RED;
					PH_RED:   phase_q <= mode_q ? PH_ALPHA : PH_BLUE;
					PH_ALPHA: phase_q <= PH_BLUE;
					default:  phase_q <= PH_BLUE;
				endcase
				if (produce) begin
					if (row_end) begin
						column_q <= '0;
						pad_q    <= padding_q;
						row_q    <= last_row ? '0 : row_next[CNT_W-1:0];
					end else begin
						column_q <= column_next[CNT_W-1:0];
					end
				end
			end
		end
	end

	// Colour byte holds.
	always_ff @(posedge clk) begin
		if (fire_s1 && !padding_byte) begin
			if (phase_q == PH_BLUE) begin
				blue_q <= byte_s1;
			end
			if (phase_q == PH_GREEN) begin
				green_q <= byte_s1;
			end
			if (phase_q == PH_RED) begin
				red_q <= byte_s1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && produce) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && produce) begin
			pixel_x_q     <= x_sat;
			pixel_y_q     <= y_sat;
			pixel_color_q <= {alpha_now, red_now, green_q, blue_q};
			image_done_q  <= row_end && last_row;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign pixel_color = pixel_color_q;
	assign image_done  = image_done_q;

endmodule
